// ----- src/bokl_pkg.sv -----
package bokl_pkg;

    localparam int MAX_ENTRIES = 16;

    localparam int KEY_W    = 24;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 4;
    localparam int CAP_W    = 5;
    localparam int OP_W     = 2;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int PI_W  = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam int PC_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // broadcast to every cell for the item being accepted
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [IDX_W-1:0]    pos_idx;
        logic                read_go;
        logic                find;
        logic                append_go;
    } cmd_t;

    // rippled left to right through the row
    typedef struct packed {
        logic   hit;
        entry_t data;
    } chain_t;

    function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W-1:0] p);
        logic [PI_W-1:0] w;
        w = PI_W'(p);
        return w[IDX_W-1:0];
    endfunction

endpackage

// ----- src/bounded_ordered_keyed_list.sv -----
// the result of an accepted item is registered and appears on the output in the next cycle
// throughput: one item per cycle while in_stall is low; the key compare and the first-match
//   ripple through the row of cells settle within that cycle
// an item is taken while the previous result waits, unless that result is stalled
// reset: entry count, capacity and output valid clear; cell contents stay
//   undefined until written
module bounded_ordered_keyed_list (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bokl_pkg::CAP_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bokl_pkg::OP_W-1:0]       op,
    input  logic [bokl_pkg::KEY_W-1:0]      entry_key,
    input  logic [bokl_pkg::HANDLE_W-1:0]   record_handle,
    input  logic [bokl_pkg::POS_W-1:0]      position,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            status,
    output logic [bokl_pkg::KEY_W-1:0]      found_key,
    output logic [bokl_pkg::HANDLE_W-1:0]   found_handle,
    output logic [bokl_pkg::CNT_W-1:0]      count
);

    localparam int N = bokl_pkg::MAX_ENTRIES;

    logic [bokl_pkg::CAP_W-1:0]    capacity_reg;
    logic [bokl_pkg::CNT_W-1:0]    count_reg;
    logic [bokl_pkg::CNT_W-1:0]    count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          status_reg;
    logic                          status_next;
    bokl_pkg::entry_t              found_reg;
    bokl_pkg::entry_t              found_next;

    logic                          accept;
    bokl_pkg::op_t                 op_code;
    logic [bokl_pkg::LIM_W-1:0]    limit;
    logic                          append_ok;
    logic                          read_ok;
    logic                          any_hit;
    logic                          remove_go;
    bokl_pkg::cmd_t                cmd;
    bokl_pkg::chain_t              chain [N+1];
    bokl_pkg::entry_t              entries [N+1];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op_code  = bokl_pkg::op_t'(op);

    always_comb
    begin
        if (bokl_pkg::LIM_W'(capacity_reg) < bokl_pkg::LIM_W'(N))
        begin
            limit = bokl_pkg::LIM_W'(capacity_reg);
        end
        else
        begin
            limit = bokl_pkg::LIM_W'(N);
        end
        append_ok = bokl_pkg::LIM_W'(count_reg) < limit;
        read_ok   = bokl_pkg::PC_W'(position) < bokl_pkg::PC_W'(count_reg);

        cmd.count     = count_reg;
        cmd.key       = entry_key;
        cmd.handle    = record_handle;
        cmd.pos_idx   = bokl_pkg::pos_to_idx(position);
        cmd.read_go   = (op_code == bokl_pkg::OP_READ) && read_ok;
        cmd.find      = (op_code == bokl_pkg::OP_FIND);
        cmd.append_go = accept && (op_code == bokl_pkg::OP_APPEND) && append_ok;
    end

    assign chain[0]   = '0;
    assign entries[N] = '0;
    assign any_hit    = chain[N].hit;
    assign remove_go  = accept && (op_code == bokl_pkg::OP_REMOVE) && any_hit;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        bokl_cell u_cell (
            .clk         (clk),
            .idx         (bokl_pkg::IDX_W'(i)),
            .cmd         (cmd),
            .remove_go   (remove_go),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1]),
            .right_entry (entries[i+1]),
            .entry       (entries[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = 1'b1;
        found_next  = '0;
        case (op_code)
            bokl_pkg::OP_APPEND:
            begin
                status_next = !append_ok;
                if (append_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            bokl_pkg::OP_REMOVE:
            begin
                status_next = !any_hit;
                if (any_hit)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bokl_pkg::OP_READ:
            begin
                status_next = !read_ok;
                if (read_ok)
                begin
                    found_next = chain[N].data;
                end
            end
            bokl_pkg::OP_FIND:
            begin
                status_next = !any_hit;
                if (any_hit)
                begin
                    found_next = chain[N].data;
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_key    = found_reg.key;
    assign found_handle = found_reg.handle;
    assign count        = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bokl_pkg::CNT_W'(N))
        else $error("entry count beyond table depth");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op_code == bokl_pkg::OP_APPEND) && append_ok
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("successful append did not grow the count");

    a_find_key: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op_code == bokl_pkg::OP_FIND)
        |=> status_reg || (found_reg.key == $past(entry_key)))
        else $error("find returned an entry with a different key");

endmodule

// ----- src/bokl_cell.sv -----
module bokl_cell (
    input  logic                 clk,
    input  logic [bokl_pkg::IDX_W-1:0] idx,
    input  bokl_pkg::cmd_t       cmd,
    input  logic                 remove_go,
    input  bokl_pkg::chain_t     chain_in,
    output bokl_pkg::chain_t     chain_out,
    input  bokl_pkg::entry_t     right_entry,
    output bokl_pkg::entry_t     entry
);

    bokl_pkg::entry_t entry_reg;
    bokl_pkg::entry_t entry_next;
    logic             in_range;
    logic             match;
    logic             sel;

    always_comb
    begin
        in_range = bokl_pkg::CNT_W'(idx) < cmd.count;
        match    = in_range && (entry_reg.key == cmd.key);
        sel      = (cmd.read_go && (idx == cmd.pos_idx))
                || (cmd.find && match && !chain_in.hit);

        chain_out.hit  = chain_in.hit | match;
        chain_out.data = sel ? entry_reg : chain_in.data;

        entry_next = entry_reg;
        // at or past the first match: close up from the right
        if (remove_go && chain_out.hit)
        begin
            entry_next = right_entry;
        end
        else if (cmd.append_go && (bokl_pkg::CNT_W'(idx) == cmd.count))
        begin
            entry_next.key    = cmd.key;
            entry_next.handle = cmd.handle;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- tb/bounded_ordered_keyed_list_tb.sv -----
`timescale 1ns / 100ps

module bounded_ordered_keyed_list_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int DIR_ROWS = 27;

    typedef struct packed {
        logic                          status;
        logic [bokl_pkg::KEY_W-1:0]    key;
        logic [bokl_pkg::HANDLE_W-1:0] handle;
        logic [bokl_pkg::CNT_W-1:0]    count;
    } result_t;

    typedef struct packed {
        logic                          is_cap;
        logic [bokl_pkg::CAP_W-1:0]    cap;
        bokl_pkg::op_t                 o;
        logic [bokl_pkg::KEY_W-1:0]    k;
        logic [bokl_pkg::HANDLE_W-1:0] h;
        logic [bokl_pkg::POS_W-1:0]    p;
        logic                          typed;
        result_t                       want;
    } step_row_t;

    localparam result_t NO_RES = '0;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [bokl_pkg::CAP_W-1:0]    cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [bokl_pkg::OP_W-1:0]     op = '0;
    logic [bokl_pkg::KEY_W-1:0]    entry_key = '0;
    logic [bokl_pkg::HANDLE_W-1:0] record_handle = '0;
    logic [bokl_pkg::POS_W-1:0]    position = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          status;
    logic [bokl_pkg::KEY_W-1:0]    found_key;
    logic [bokl_pkg::HANDLE_W-1:0] found_handle;
    logic [bokl_pkg::CNT_W-1:0]    count;

    // predictor state
    logic [bokl_pkg::KEY_W-1:0]    keys_held [bokl_pkg::MAX_ENTRIES];
    logic [bokl_pkg::HANDLE_W-1:0] handles_held [bokl_pkg::MAX_ENTRIES];
    int                            held = 0;
    logic [bokl_pkg::CAP_W-1:0]    cap_limit = '0;

    result_t pending_results [$];
    int      errors = 0;
    int      cycle_count = 0;
    int      send_pct = 0;
    int      recv_pct = 0;
    int      hold_requests = 0;
    int      hold_served = 0;
    int      hold_left = 0;

    step_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{1'b1, 5'd0,  bokl_pkg::OP_APPEND, 24'h000000, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'hFFFFFF, 16'hFFFF, 4'd0,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd0}},
        '{1'b0, 5'd0,  bokl_pkg::OP_REMOVE, 24'h000000, 16'h0000, 4'd0,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd0}},
        '{1'b0, 5'd0,  bokl_pkg::OP_READ,   24'h000000, 16'h0000, 4'd0,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd0}},
        '{1'b0, 5'd0,  bokl_pkg::OP_FIND,   24'h000000, 16'h0000, 4'd0,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd0}},
        '{1'b1, 5'd2,  bokl_pkg::OP_APPEND, 24'h000000, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'hFFFFFF, 16'hFFFF, 4'd0,  1'b1,
          '{1'b0, 24'h0, 16'h0, 5'd1}},
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'h000000, 16'h0000, 4'd15, 1'b1,
          '{1'b0, 24'h0, 16'h0, 5'd2}},
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'h000005, 16'h0005, 4'd0,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd2}},
        '{1'b0, 5'd0,  bokl_pkg::OP_READ,   24'h000000, 16'h0000, 4'd0,  1'b1,
          '{1'b0, 24'hFFFFFF, 16'hFFFF, 5'd2}},
        '{1'b0, 5'd0,  bokl_pkg::OP_READ,   24'hFFFFFF, 16'hFFFF, 4'd15, 1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd2}},
        '{1'b0, 5'd0,  bokl_pkg::OP_READ,   24'h000000, 16'h0000, 4'd2,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd2}},
        // capacity lowered below the count
        '{1'b1, 5'd1,  bokl_pkg::OP_APPEND, 24'h000000, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'h123456, 16'hABCD, 4'd0,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd2}},
        '{1'b0, 5'd0,  bokl_pkg::OP_REMOVE, 24'hFFFFFF, 16'h0000, 4'd0,  1'b1,
          '{1'b0, 24'h0, 16'h0, 5'd1}},
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'h654321, 16'h1234, 4'd0,  1'b1,
          '{1'b1, 24'h0, 16'h0, 5'd1}},
        '{1'b1, 5'd31, bokl_pkg::OP_APPEND, 24'h000000, 16'h0000, 4'd0,  1'b0, NO_RES},
        // duplicate keys: find and remove take the first one
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'h000007, 16'h0001, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_APPEND, 24'h000007, 16'h0002, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_FIND,   24'h000007, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_REMOVE, 24'h000007, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_FIND,   24'h000007, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_REMOVE, 24'h123456, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_READ,   24'h000000, 16'h0000, 4'd1,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_REMOVE, 24'h000000, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_REMOVE, 24'h000007, 16'h0000, 4'd0,  1'b0, NO_RES},
        '{1'b0, 5'd0,  bokl_pkg::OP_FIND,   24'h000000, 16'h0000, 4'd0,  1'b0, NO_RES}
    };

    bounded_ordered_keyed_list i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .entry_key    (entry_key),
        .record_handle(record_handle),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_key    (found_key),
        .found_handle (found_handle),
        .count        (count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // applies one operation to the table copy and returns its result
    function automatic result_t list_apply(input bokl_pkg::op_t o,
                                           input logic [bokl_pkg::KEY_W-1:0] k,
                                           input logic [bokl_pkg::HANDLE_W-1:0] h,
                                           input logic [bokl_pkg::POS_W-1:0] p);
        result_t r;
        int      lim;
        int      hit;
        int      j;
        r = '0;
        r.status = 1'b1;
        lim = (int'(cap_limit) < bokl_pkg::MAX_ENTRIES) ? int'(cap_limit)
                                                        : bokl_pkg::MAX_ENTRIES;
        hit = held;
        for (j = held - 1; j >= 0; j--)
        begin
            if (keys_held[j] == k)
                hit = j;
        end
        case (o)
            bokl_pkg::OP_APPEND:
            begin
                if (held < lim)
                begin
                    keys_held[held] = k;
                    handles_held[held] = h;
                    held++;
                    r.status = 1'b0;
                end
            end
            bokl_pkg::OP_REMOVE:
            begin
                if (hit < held)
                begin
                    for (j = hit; j + 1 < held; j++)
                    begin
                        keys_held[j] = keys_held[j + 1];
                        handles_held[j] = handles_held[j + 1];
                    end
                    held--;
                    r.status = 1'b0;
                end
            end
            bokl_pkg::OP_READ:
            begin
                if (int'(p) < held)
                begin
                    r.key = keys_held[p];
                    r.handle = handles_held[p];
                    r.status = 1'b0;
                end
            end
            default:
            begin
                if (hit < held)
                begin
                    r.key = keys_held[hit];
                    r.handle = handles_held[hit];
                    r.status = 1'b0;
                end
            end
        endcase
        r.count = bokl_pkg::CNT_W'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [bokl_pkg::KEY_W-1:0] got,
                                   input logic [bokl_pkg::KEY_W-1:0] want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // returns at the edge where the item is taken
    task automatic send_item(input bokl_pkg::op_t o, input logic [bokl_pkg::KEY_W-1:0] k,
                             input logic [bokl_pkg::HANDLE_W-1:0] h,
                             input logic [bokl_pkg::POS_W-1:0] p);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        entry_key <= k;
        record_handle <= h;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [bokl_pkg::CAP_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        cap_limit = v;
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_served <= hold_served + 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no item pending", found_key, '0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", bokl_pkg::KEY_W'(status),
                                    bokl_pkg::KEY_W'(want.status));
                if (found_key !== want.key)
                    report_mismatch("found_key", found_key, want.key);
                if (found_handle !== want.handle)
                    report_mismatch("found_handle", bokl_pkg::KEY_W'(found_handle),
                                    bokl_pkg::KEY_W'(want.handle));
                if (count !== want.count)
                    report_mismatch("count", bokl_pkg::KEY_W'(count),
                                    bokl_pkg::KEY_W'(want.count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bounded_ordered_keyed_list test failed");
            $finish;
        end
    end

    initial
    begin
        logic [bokl_pkg::KEY_W-1:0]    key_pool [8];
        logic [bokl_pkg::CAP_W-1:0]    phase_caps [PHASES];
        result_t                       want;
        bokl_pkg::op_t                 o;
        logic [bokl_pkg::KEY_W-1:0]    k;
        logic [bokl_pkg::HANDLE_W-1:0] h;
        logic [bokl_pkg::POS_W-1:0]    p;
        int                            i;
        int                            ph;
        int                            r;
        int                            app_w;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < 8; i++)
            key_pool[i] = bokl_pkg::KEY_W'($urandom);
        phase_caps[0] = 5'd16;
        phase_caps[1] = 5'd3;
        phase_caps[2] = 5'd31;
        phase_caps[3] = bokl_pkg::CAP_W'($urandom_range(0, 31));
        phase_caps[4] = 5'd1;
        phase_caps[5] = 5'd16;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pct = 19;
        recv_pct = 71;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].is_cap)
                set_capacity(dir_rows[i].cap);
            else
            begin
                send_item(dir_rows[i].o, dir_rows[i].k, dir_rows[i].h, dir_rows[i].p);
                want = list_apply(dir_rows[i].o, dir_rows[i].k, dir_rows[i].h, dir_rows[i].p);
                if (dir_rows[i].typed)
                    want = dir_rows[i].want;
                pending_results.push_back(want);
            end
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 2)
            begin
                send_pct = 19;
                recv_pct = 71;
            end
            else if (ph < 4)
            begin
                send_pct = 71;
                recv_pct = 19;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            set_capacity(phase_caps[ph]);
            // even phases fill the table, odd ones drain it
            app_w = (ph % 2 == 0) ? 40 : 22;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i == 20 && (ph == 0 || ph == 4))
                    hold_requests++;
                r = $urandom_range(99);
                if (r < app_w)
                    o = bokl_pkg::OP_APPEND;
                else if (r < app_w + 25)
                    o = bokl_pkg::OP_REMOVE;
                else if (r < app_w + 50)
                    o = bokl_pkg::OP_READ;
                else
                    o = bokl_pkg::OP_FIND;
                k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)]
                                              : bokl_pkg::KEY_W'($urandom);
                h = bokl_pkg::HANDLE_W'($urandom);
                if (held > 0 && $urandom_range(99) < 70)
                    p = bokl_pkg::POS_W'($urandom_range(held - 1));
                else
                    p = bokl_pkg::POS_W'($urandom);
                send_item(o, k, h, p);
                pending_results.push_back(list_apply(o, k, h, p));
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("bounded_ordered_keyed_list test passed");
        else
            $display("bounded_ordered_keyed_list test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bokl_pkg.sv
src/bokl_cell.sv
src/bounded_ordered_keyed_list.sv
tb/bounded_ordered_keyed_list_tb.sv
